/* sv/vtr_pkg.sv */
// shared widths, types and index tables for the voigt tensor rotation block
// no dependencies; imported by vtr_coef and voigt_tensor_rotation_top
package vtr_pkg;

    localparam int CW  = 32;            // component width, q15.16
    localparam int AW  = 16;            // axis width, q1.14
    localparam int AF  = AW - 2;        // axis fraction bits
    localparam int PRW = 2 * AW;        // axis by axis product
    localparam int CFW = 2 * AW + 1 - AF; // rounded coefficient
    localparam int PW  = CW + CFW;      // coefficient by component product
    localparam int SW  = PW + 2;        // partial sum of three products
    localparam int ACW = PW + 4;        // full sum of nine products
    localparam int NIO = 9;

    localparam logic [2:0] MODE_STRAIN_FWD = 3'd0;
    localparam logic [2:0] MODE_STRAIN_BCK = 3'd1;
    localparam logic [2:0] MODE_STRESS_FWD = 3'd2;
    localparam logic [2:0] MODE_STRESS_BCK = 3'd3;
    localparam logic [2:0] MODE_GRAD_FWD   = 3'd4;

    localparam logic [2:0] REG_AXIS1_X = 3'd0;
    localparam logic [2:0] REG_AXIS1_Y = 3'd1;
    localparam logic [2:0] REG_AXIS1_Z = 3'd2;
    localparam logic [2:0] REG_AXIS2_X = 3'd3;
    localparam logic [2:0] REG_AXIS2_Y = 3'd4;
    localparam logic [2:0] REG_AXIS2_Z = 3'd5;

    typedef logic signed [AW-1:0]  axis_t;
    typedef logic signed [CFW-1:0] coef_t;
    typedef logic signed [CW-1:0]  comp_t;

    typedef struct {
        coef_t grad [NIO][NIO];
        coef_t voigt [4][6][6];
    } coef_tab_t;

    // voigt order xx,yy,zz,xy,xz,yz
    function automatic int vrow(input int k);
        case (k)
            1, 5:    vrow = 1;
            2:       vrow = 2;
            default: vrow = 0;
        endcase
    endfunction

    function automatic int vcol(input int k);
        case (k)
            1, 3:    vcol = 1;
            2, 4, 5: vcol = 2;
            default: vcol = 0;
        endcase
    endfunction

    // a*b - c*d, rounded half up to the axis format and saturated
    function automatic axis_t cross_term(input axis_t a, input axis_t b,
                                         input axis_t c, input axis_t d);
        logic signed [PRW:0]  diff;
        logic signed [PRW-AF:0] sh;
        diff = (PRW+1)'(a) * (PRW+1)'(b) - (PRW+1)'(c) * (PRW+1)'(d)
               + (PRW+1)'(1 <<< (AF - 1));
        sh = diff[PRW:AF];
        if (sh > (PRW-AF+1)'((1 <<< (AW - 1)) - 1))
            cross_term = axis_t'((1 <<< (AW - 1)) - 1);
        else if (sh < -(PRW-AF+1)'(1 <<< (AW - 1)))
            cross_term = axis_t'(-(1 <<< (AW - 1)));
        else
            cross_term = sh[AW-1:0];
    endfunction

    // round an exact q.2f coefficient down to f fraction bits
    function automatic coef_t coef_round(input logic signed [PRW:0] v);
        logic signed [PRW:0] t;
        t = v + (PRW+1)'(1 <<< (AF - 1));
        coef_round = t[PRW:AF];
    endfunction

endpackage

/* sv/vtr_coef.sv */
// coefficient tables derived from the two configured axes
// depends on vtr_pkg; three register stages: rotation, axis products, coefficients
module vtr_coef (
    input  logic              aclk,
    input  vtr_pkg::axis_t    axis [2][3],
    output vtr_pkg::coef_tab_t tab
);
    import vtr_pkg::*;

    axis_t r_reg [3][3];
    logic signed [PRW-1:0] pr_reg [3][3][3][3];
    coef_tab_t tab_reg;
    coef_tab_t tab_next;

    // rotation matrix, third row is the rounded cross product
    always_ff @(posedge aclk) begin
        for (int b = 0; b < 3; b++) begin
            r_reg[0][b] <= axis[0][b];
            r_reg[1][b] <= axis[1][b];
        end
        r_reg[2][0] <= cross_term(axis[0][1], axis[1][2], axis[1][1], axis[0][2]);
        r_reg[2][1] <= cross_term(axis[1][0], axis[0][2], axis[1][2], axis[0][0]);
        r_reg[2][2] <= cross_term(axis[0][0], axis[1][1], axis[1][0], axis[0][1]);
    end

    always_ff @(posedge aclk) begin
        for (int a = 0; a < 3; a++)
            for (int b = 0; b < 3; b++)
                for (int c = 0; c < 3; c++)
                    for (int d = 0; d < 3; d++)
                        pr_reg[a][b][c][d] <= PRW'(r_reg[a][b]) * PRW'(r_reg[c][d]);
    end

    always_comb begin
        int p, q, i, j;
        logic back, strain;
        logic signed [PRW:0] base, other, coef;
        for (int k = 0; k < NIO; k++)
            for (int m = 0; m < NIO; m++)
                tab_next.grad[k][m] =
                    coef_round((PRW+1)'(pr_reg[k/3][m/3][k%3][m%3]));
        for (int md = 0; md < 4; md++) begin
            back   = (md % 2) == 1;
            strain = md < 2;
            for (int k = 0; k < 6; k++) begin
                for (int m = 0; m < 6; m++) begin
                    p = vrow(k);
                    q = vcol(k);
                    i = vrow(m);
                    j = vcol(m);
                    if (back) begin
                        base  = (PRW+1)'(pr_reg[i][p][j][q]);
                        other = (PRW+1)'(pr_reg[j][p][i][q]);
                    end else begin
                        base  = (PRW+1)'(pr_reg[p][i][q][j]);
                        other = (PRW+1)'(pr_reg[p][j][q][i]);
                    end
                    if (strain && p == q && i != j)
                        coef = base;
                    else if (strain && p != q && i == j)
                        coef = base + base;
                    else if (i != j)
                        coef = base + other;
                    else
                        coef = base;
                    tab_next.voigt[md][k][m] = coef_round(coef);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        tab_reg <= tab_next;
    end

    assign tab = tab_reg;

endmodule

/* sv/voigt_tensor_rotation_top.sv */
// voigt tensor rotation top level: config registers, item pipeline, output register
// depends on vtr_pkg and vtr_coef
//
//  channel   direction  handshake            payload
//  s_        in         s_valid / s_ready    s_mode, s_in_0 .. s_in_8
//  m_        out        m_valid / m_ready    m_out_0 .. m_out_8
//  cfg_      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one request per cycle unless stalled or settling; m_valid follows the v1, v2, v3 regs
// stages: coefficient by component multiply, partial sums of three, final sum with round
// and saturate into the output register
// coefficient tables settle through the vtr_coef registers after reset or a config write; s_ready
// stays low meanwhile, config writes are always taken
// each stage holds only while it is full and the stage after it is stalled
module voigt_tensor_rotation_top (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [2:0]          s_mode,
    input  vtr_pkg::comp_t      s_in_0,
    input  vtr_pkg::comp_t      s_in_1,
    input  vtr_pkg::comp_t      s_in_2,
    input  vtr_pkg::comp_t      s_in_3,
    input  vtr_pkg::comp_t      s_in_4,
    input  vtr_pkg::comp_t      s_in_5,
    input  vtr_pkg::comp_t      s_in_6,
    input  vtr_pkg::comp_t      s_in_7,
    input  vtr_pkg::comp_t      s_in_8,
    output logic                m_valid,
    input  logic                m_ready,
    output vtr_pkg::comp_t      m_out_0,
    output vtr_pkg::comp_t      m_out_1,
    output vtr_pkg::comp_t      m_out_2,
    output vtr_pkg::comp_t      m_out_3,
    output vtr_pkg::comp_t      m_out_4,
    output vtr_pkg::comp_t      m_out_5,
    output vtr_pkg::comp_t      m_out_6,
    output vtr_pkg::comp_t      m_out_7,
    output vtr_pkg::comp_t      m_out_8,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  vtr_pkg::axis_t      cfg_data
);
    import vtr_pkg::*;

    localparam logic [1:0] SETTLE_CYC = 2'd3;

    // config registers, row 0 is axis1 and row 1 is axis2
    axis_t axis_reg [2][3];
    logic [1:0] settle_reg;
    coef_tab_t tab;

    logic cfg_wr;
    assign cfg_ready = 1'b1;
    assign cfg_wr = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_reg[0][0] <= axis_t'(1 <<< AF);
            axis_reg[0][1] <= '0;
            axis_reg[0][2] <= '0;
            axis_reg[1][0] <= '0;
            axis_reg[1][1] <= axis_t'(1 <<< AF);
            axis_reg[1][2] <= '0;
        end else if (cfg_wr) begin
            case (cfg_index)
                REG_AXIS1_X: axis_reg[0][0] <= cfg_data;
                REG_AXIS1_Y: axis_reg[0][1] <= cfg_data;
                REG_AXIS1_Z: axis_reg[0][2] <= cfg_data;
                REG_AXIS2_X: axis_reg[1][0] <= cfg_data;
                REG_AXIS2_Y: axis_reg[1][1] <= cfg_data;
                REG_AXIS2_Z: axis_reg[1][2] <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // hold off input requests until the derived tables reflect the axes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= SETTLE_CYC;
        end else if (cfg_wr) begin
            settle_reg <= SETTLE_CYC;
        end else if (settle_reg != 2'd0) begin
            settle_reg <= settle_reg - 2'd1;
        end
    end

    vtr_coef u_coef (
        .aclk (aclk),
        .axis (axis_reg),
        .tab  (tab)
    );

    // pipeline control: valid bits travel with the data
    logic v1_reg, v2_reg, v3_reg;
    logic en1, en2, en3, s_acc;

    assign en3   = !v3_reg || m_ready;
    assign en2   = !v2_reg || en3;
    assign en1   = !v1_reg || en2;
    assign s_ready = en1 && (settle_reg == 2'd0);
    assign s_acc = s_valid && s_ready;
    assign m_valid = v3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en1)
                v1_reg <= s_acc;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
        end
    end

    // coefficient matrix for the request's mode; unused rows, columns and modes give zero
    comp_t x [NIO];
    coef_t csel [NIO][NIO];

    assign x[0] = s_in_0;
    assign x[1] = s_in_1;
    assign x[2] = s_in_2;
    assign x[3] = s_in_3;
    assign x[4] = s_in_4;
    assign x[5] = s_in_5;
    assign x[6] = s_in_6;
    assign x[7] = s_in_7;
    assign x[8] = s_in_8;

    always_comb begin
        for (int k = 0; k < NIO; k++)
            for (int m = 0; m < NIO; m++)
                csel[k][m] = '0;
        case (s_mode)
            MODE_STRAIN_FWD, MODE_STRAIN_BCK, MODE_STRESS_FWD, MODE_STRESS_BCK: begin
                for (int k = 0; k < 6; k++)
                    for (int m = 0; m < 6; m++)
                        csel[k][m] = tab.voigt[s_mode[1:0]][k][m];
            end
            MODE_GRAD_FWD: begin
                for (int k = 0; k < NIO; k++)
                    for (int m = 0; m < NIO; m++)
                        csel[k][m] = tab.grad[k][m];
            end
            default: begin
            end
        endcase
    end

    // stage 1: 81 coefficient by component products
    logic signed [PW-1:0] p1_reg [NIO][NIO];

    always_ff @(posedge aclk) begin
        if (en1 && s_acc) begin
            for (int k = 0; k < NIO; k++)
                for (int m = 0; m < NIO; m++)
                    p1_reg[k][m] <= PW'(csel[k][m]) * PW'(x[m]);
        end
    end

    // stage 2: three partial sums per output
    logic signed [SW-1:0] s2_reg [NIO][3];

    always_ff @(posedge aclk) begin
        if (en2 && v1_reg) begin
            for (int k = 0; k < NIO; k++)
                for (int g = 0; g < 3; g++)
                    s2_reg[k][g] <= SW'(p1_reg[k][3*g]) + SW'(p1_reg[k][3*g+1])
                                    + SW'(p1_reg[k][3*g+2]);
        end
    end

    // stage 3: final sum, round half up, saturate into the output register
    comp_t out_reg [NIO];
    comp_t out_next [NIO];

    always_comb begin
        logic signed [ACW-1:0] acc;
        logic signed [ACW-AF-1:0] sh;
        for (int k = 0; k < NIO; k++) begin
            acc = ACW'(s2_reg[k][0]) + ACW'(s2_reg[k][1]) + ACW'(s2_reg[k][2])
                  + ACW'(1 <<< (AF - 1));
            sh = acc[ACW-1:AF];
            if (sh > (ACW-AF)'((64'sd1 <<< (CW - 1)) - 1))
                out_next[k] = comp_t'((64'sd1 <<< (CW - 1)) - 1);
            else if (sh < -(ACW-AF)'(64'sd1 <<< (CW - 1)))
                out_next[k] = comp_t'(-(64'sd1 <<< (CW - 1)));
            else
                out_next[k] = sh[CW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en3 && v2_reg) begin
            for (int k = 0; k < NIO; k++)
                out_reg[k] <= out_next[k];
        end
    end

    assign m_out_0 = out_reg[0];
    assign m_out_1 = out_reg[1];
    assign m_out_2 = out_reg[2];
    assign m_out_3 = out_reg[3];
    assign m_out_4 = out_reg[4];
    assign m_out_5 = out_reg[5];
    assign m_out_6 = out_reg[6];
    assign m_out_7 = out_reg[7];
    assign m_out_8 = out_reg[8];

    // a config write blocks input requests on the following cycle
    a_cfg_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input request taken while coefficient tables settle");

    // a fresh stage 1 entry only comes from an accepted request
    a_stage1_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (v1_reg && !$past(v1_reg)) |-> $past(s_valid && s_ready))
        else $error("stage 1 filled without an input request");

    // a result appears only after stage 2 held one
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(v3_reg) |-> $past(v2_reg))
        else $error("result shown without a stage 2 request");

endmodule
